/* rtl/kmab_pkg.sv */
package kmab_pkg;

   localparam int unsigned ALPHA_COUNT = 26;
   localparam int unsigned IDX_W       = 5;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LETTER_W    = 7;

   localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(ALPHA_COUNT - 1);
   localparam logic [BYTE_W-1:0]   LOWER_GAP  = 8'd32;
   localparam logic [BYTE_W-1:0]   UPPER_A    = 8'd65;
   localparam logic [BYTE_W-1:0]   UPPER_Z    = 8'd90;
   localparam logic [BYTE_W-1:0]   LOWER_A    = 8'd97;
   localparam logic [BYTE_W-1:0]   LOWER_Z    = 8'd122;
   localparam logic [LETTER_W-1:0] LETTER_A   = 7'd65;

   typedef logic [ALPHA_COUNT-1:0] mask_type;

   typedef struct packed {
      logic take_byte;
      logic emit_byte;
      logic start_drain;
      logic scan_step;
      logic emit_scan;
      logic finish;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic byte_new;
      logic scan_hit;
      logic scan_last;
      logic rsp_valid;
   } status_type;

endpackage

/* rtl/kmab_ctrl.sv */
module kmab_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_terminator,
   output logic                  req_stall,
   input  logic                  rsp_stall,
   input  kmab_pkg::status_type  status,
   output kmab_pkg::cmd_type     cmd
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff;
   logic state_in;
   logic out_free;
   logic accept;
   logic drain;

   assign out_free  = !status.rsp_valid || !rsp_stall;
   assign drain     = (state_ff == ST_DRAIN);
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd             = '0;
      cmd.take_byte   = accept && !req_terminator;
      cmd.emit_byte   = accept && !req_terminator && status.byte_new;
      cmd.start_drain = accept && req_terminator;
      cmd.emit_scan   = drain && status.scan_hit && out_free;
      cmd.scan_step   = drain && (!status.scan_hit || out_free);
      cmd.finish      = drain && (!status.scan_hit || out_free) && status.scan_last;
      cmd.pop         = status.rsp_valid && !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start_drain) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/kmab_dp.sv */
module kmab_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [kmab_pkg::BYTE_W-1:0]          req_phrase_byte,
   input  kmab_pkg::cmd_type                    cmd,
   output kmab_pkg::status_type                 status,
   output logic                                 rsp_valid,
   output logic [kmab_pkg::LETTER_W-1:0]        rsp_key_letter,
   output logic [kmab_pkg::IDX_W-1:0]           rsp_key_position,
   output logic                                 rsp_key_done
);

   kmab_pkg::mask_type              used_ff, used_in;
   logic [kmab_pkg::IDX_W-1:0]      count_ff, count_in;
   logic                            seen_ff, seen_in;
   logic                            empty_ff, empty_in;
   logic [kmab_pkg::IDX_W-1:0]      scan_ff, scan_in;
   logic                            valid_ff, valid_in;
   logic [kmab_pkg::LETTER_W-1:0]   letter_ff, letter_in;
   logic [kmab_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic                            done_ff, done_in;

   logic [kmab_pkg::BYTE_W-1:0]     upper;
   logic                            is_letter;
   logic [kmab_pkg::IDX_W-1:0]      byte_idx;
   logic [kmab_pkg::IDX_W-1:0]      scan_idx;
   logic [kmab_pkg::IDX_W-1:0]      emit_idx;
   logic                            emit;

   always_comb begin
      upper = req_phrase_byte;
      if (req_phrase_byte inside {[kmab_pkg::LOWER_A:kmab_pkg::LOWER_Z]}) begin
         upper = req_phrase_byte - kmab_pkg::LOWER_GAP;
      end
   end

   assign is_letter = upper inside {[kmab_pkg::UPPER_A:kmab_pkg::UPPER_Z]};
   assign byte_idx  = kmab_pkg::IDX_W'(upper - kmab_pkg::UPPER_A);
   assign scan_idx  = empty_ff ? (kmab_pkg::LAST_IDX - scan_ff) : scan_ff;

   always_comb begin
      status           = '0;
      status.byte_new  = is_letter && !used_ff[byte_idx];
      status.scan_hit  = empty_ff || !used_ff[scan_idx];
      status.scan_last = (scan_ff == kmab_pkg::LAST_IDX);
      status.rsp_valid = valid_ff;
   end

   assign emit     = cmd.emit_byte || cmd.emit_scan;
   assign emit_idx = cmd.emit_byte ? byte_idx : scan_idx;

   always_comb begin
      used_in   = used_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      empty_in  = empty_ff;
      scan_in   = scan_ff;
      valid_in  = valid_ff;
      letter_in = letter_ff;
      pos_in    = pos_ff;
      done_in   = done_ff;

      // retire the word on the result side
      if (cmd.pop) begin
         valid_in = 1'b0;
      end
      if (emit) begin
         valid_in  = 1'b1;
         letter_in = kmab_pkg::LETTER_A + kmab_pkg::LETTER_W'(emit_idx);
         pos_in    = count_ff;
         done_in   = (count_ff == kmab_pkg::LAST_IDX);
         used_in   = used_ff | (kmab_pkg::mask_type'(1) << emit_idx);
         count_in  = count_ff + kmab_pkg::IDX_W'(1);
      end
      if (cmd.take_byte) begin
         seen_in = 1'b1;
      end
      if (cmd.start_drain) begin
         empty_in = !seen_ff;
         scan_in  = '0;
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + kmab_pkg::IDX_W'(1);
      end
      // drop all key state after the last scan step
      if (cmd.finish) begin
         used_in  = '0;
         count_in = '0;
         seen_in  = 1'b0;
         empty_in = 1'b0;
         scan_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
         seen_ff  <= 1'b0;
         empty_ff <= 1'b0;
         scan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
         seen_ff  <= seen_in;
         empty_ff <= empty_in;
         scan_ff  <= scan_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      letter_ff <= letter_in;
      pos_ff    <= pos_in;
      done_ff   <= done_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_key_letter   = letter_ff;
   assign rsp_key_position = pos_ff;
   assign rsp_key_done     = done_ff;

endmodule

/* rtl/keyword_mixed_alphabet_builder.sv */
// A new phrase letter appears on rsp in the cycle after its byte is accepted.
// One phrase byte is taken per cycle while no scan runs and the result register drains.
// A terminator starts a 26-step scan over A..Z (Z..A for an empty phrase), one
// letter index per cycle plus result stalls; no input is taken during the scan.
// Reset is synchronous, active high, and clears the used mask, counters and state.
module keyword_mixed_alphabet_builder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kmab_pkg::BYTE_W-1:0]          req_phrase_byte,
   input  logic                                 req_terminator,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [kmab_pkg::LETTER_W-1:0]        rsp_key_letter,
   output logic [kmab_pkg::IDX_W-1:0]           rsp_key_position,
   output logic                                 rsp_key_done
);

   kmab_pkg::cmd_type    cmd;
   kmab_pkg::status_type status;

   kmab_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_terminator (req_terminator),
      .req_stall      (req_stall),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   kmab_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_phrase_byte  (req_phrase_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_key_letter   (rsp_key_letter),
      .rsp_key_position (rsp_key_position),
      .rsp_key_done     (rsp_key_done)
   );

endmodule

/* rtl/kmab_checker.sv */
module kmab_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_terminator,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [kmab_pkg::LETTER_W-1:0]        rsp_key_letter,
   input logic [kmab_pkg::IDX_W-1:0]           rsp_key_position,
   input logic                                 rsp_key_done
);

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_letter)
         && $stable(rsp_key_position) && $stable(rsp_key_done))
      else $error("result word changed while stalled");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_done == (rsp_key_position == kmab_pkg::LAST_IDX)))
      else $error("done flag does not match last position");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_key_letter >= 7'd65) && (rsp_key_letter <= 7'd90))
      else $error("key letter outside A..Z");

   a_term_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_terminator |=> req_stall)
      else $error("input taken right after terminator");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_key_done ##1 rsp_valid
         |-> rsp_key_position == $past(rsp_key_position) + 5'd1)
      else $error("key position skipped");

endmodule

bind keyword_mixed_alphabet_builder kmab_checker u_kmab_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_terminator   (req_terminator),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_key_letter   (rsp_key_letter),
   .rsp_key_position (rsp_key_position),
   .rsp_key_done     (rsp_key_done)
);
